// File: src/crcfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame deframer package
// Shared types, status codes, register indexes and the byte-wide
// CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
package crcfd_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_START = 3'd2;
    localparam logic [2:0] ST_BAD_VER   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [2:0] ST_CRC_BAD   = 3'd5;

    localparam logic [1:0] REG_START_WORD  = 2'd0;
    localparam logic [1:0] REG_VERSION     = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] LIMIT_CAP = 16'd65520;
    localparam logic [15:0] HDR_LEN   = 16'd13;

    // One result item on its way to the output.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [15:0] msg_id;
        logic [15:0] sequence_res;
        logic [31:0] timestamp;
        logic [15:0] payload_length;
        logic [15:0] received_crc;
    } res_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: src/crcfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame deframer front end
// Walks the frame byte by byte, runs the CRC and produces result items.
// ----------------------------------------------------------------------------
module crcfd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_end,
    input  logic [15:0]        start_word,
    input  logic [7:0]         version_value,
    input  logic [15:0]        max_payload,
    output logic               res_valid,
    output crcfd_pkg::res_t    res
);

    logic [15:0] pos_reg, crc_reg, id_reg, seq_reg, len_reg;
    logic [31:0] time_reg;
    logic [7:0]  low_reg;
    logic        sbad_reg, vbad_reg, rep_reg;
    logic [15:0] pos_next, crc_next, id_next, seq_next, len_next;
    logic [31:0] time_next;
    logic [7:0]  low_next;
    logic        sbad_next, vbad_next, rep_next;

    logic [15:0] lim;
    logic [16:0] pay_end;
    logic [15:0] rcv;
    logic        summ;
    logic [2:0]  st;

    assign lim     = (max_payload > crcfd_pkg::LIMIT_CAP) ? crcfd_pkg::LIMIT_CAP : max_payload;
    assign pay_end = {1'b0, len_reg} + {1'b0, crcfd_pkg::HDR_LEN};
    assign rcv     = {in_byte, low_reg};

    always_comb begin
        pos_next = pos_reg; crc_next = crc_reg; id_next = id_reg; seq_next = seq_reg;
        len_next = len_reg; time_next = time_reg; low_next = low_reg;
        sbad_next = sbad_reg; vbad_next = vbad_reg; rep_next = rep_reg;
        res_valid = 1'b0;
        res = '0;
        summ = 1'b0;
        st = crcfd_pkg::ST_OK;
        if (in_valid && !rep_reg) begin
            if (pos_reg <= 16'd12) begin
                crc_next = crcfd_pkg::crc_feed(crc_reg, in_byte);
                case (pos_reg[3:0])
                    4'd0: low_next = in_byte;
                    4'd1: sbad_next = ({in_byte, low_reg} != start_word);
                    4'd2: vbad_next = (in_byte != version_value);
                    4'd3: id_next[7:0] = in_byte;
                    4'd4: id_next[15:8] = in_byte;
                    4'd5: seq_next[7:0] = in_byte;
                    4'd6: seq_next[15:8] = in_byte;
                    4'd7: time_next[7:0] = in_byte;
                    4'd8: time_next[15:8] = in_byte;
                    4'd9: time_next[23:16] = in_byte;
                    4'd10: time_next[31:24] = in_byte;
                    4'd11: len_next[7:0] = in_byte;
                    default: len_next[15:8] = in_byte;
                endcase
            end else if (sbad_reg || vbad_reg || len_reg > lim) begin
                if (pos_reg >= 16'd14) begin
                    summ = 1'b1;
                    st = sbad_reg ? crcfd_pkg::ST_BAD_START :
                         (vbad_reg ? crcfd_pkg::ST_BAD_VER : crcfd_pkg::ST_TOO_LONG);
                end
            end else if ({1'b0, pos_reg} < pay_end) begin
                crc_next = crcfd_pkg::crc_feed(crc_reg, in_byte);
                res_valid = 1'b1;
                res.payload_byte = in_byte;
            end else if ({1'b0, pos_reg} == pay_end) begin
                low_next = in_byte;
            end else begin
                summ = 1'b1;
                st = (rcv == crc_reg) ? crcfd_pkg::ST_OK : crcfd_pkg::ST_CRC_BAD;
            end
            if (!summ && in_end) begin
                summ = 1'b1;
                st = crcfd_pkg::ST_SHORT;
            end
            if (summ) begin
                res_valid = 1'b1;
                res = '0;
                res.kind = 1'b1;
                res.status = st;
                if (st != crcfd_pkg::ST_SHORT) begin
                    res.msg_id = id_reg;
                    res.sequence_res = seq_reg;
                    res.timestamp = time_reg;
                    res.payload_length = len_reg;
                end
                if (st == crcfd_pkg::ST_OK || st == crcfd_pkg::ST_CRC_BAD) begin
                    res.received_crc = rcv;
                end
                rep_next = 1'b1;
            end
            if (pos_reg != 16'hFFFF) pos_next = pos_reg + 16'd1;
        end
        if (in_valid && in_end) begin
            pos_next = '0; crc_next = crcfd_pkg::CRC_INIT; id_next = '0; seq_next = '0;
            len_next = '0; time_next = '0; low_next = '0;
            sbad_next = 1'b0; vbad_next = 1'b0; rep_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0; crc_reg <= crcfd_pkg::CRC_INIT; id_reg <= '0; seq_reg <= '0;
            len_reg <= '0; time_reg <= '0; low_reg <= '0;
            sbad_reg <= 1'b0; vbad_reg <= 1'b0; rep_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next; crc_reg <= crc_next; id_reg <= id_next; seq_reg <= seq_next;
            len_reg <= len_next; time_reg <= time_next; low_reg <= low_next;
            sbad_reg <= sbad_next; vbad_reg <= vbad_next; rep_reg <= rep_next;
        end
    end

endmodule

// File: src/crcfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame deframer result queue
// Four-entry queue of result items between the front end and the output.
// ----------------------------------------------------------------------------
module crcfd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  crcfd_pkg::res_t    wr_data,
    output logic               has_room,
    output logic               rd_valid,
    output crcfd_pkg::res_t    rd_data,
    input  logic               rd_en
);

    crcfd_pkg::res_t mem [4];
    logic [1:0] wp_reg, rp_reg, wp_next, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign do_wr    = wr_en;
    assign do_rd    = rd_en && (cnt_reg != 3'd0);
    assign has_room = (cnt_reg < 3'd3);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem[rp_reg];
    assign wp_next  = do_wr ? wp_reg + 2'd1 : wp_reg;
    assign rp_next  = do_rd ? rp_reg + 2'd1 : rp_reg;
    assign cnt_next = cnt_reg + {2'b0, do_wr} - {2'b0, do_rd};

    always_ff @(posedge aclk) begin
        if (do_wr) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next;
        end
    end

endmodule

// File: src/crc16_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame deframer
// Decodes one length-prefixed, CRC-16/CCITT-FALSE protected frame per buffer.
// ----------------------------------------------------------------------------
// Bytes of a receive buffer enter on the s_ channel, tlast on the buffer's
// last byte. The front end runs a byte-wide CRC update and accepts a byte
// every cycle while the result queue has room. Result items leave on the
// m_ channel: payload bytes (tuser kind 0) as they arrive and one frame
// summary (kind 1) with status and header fields. Each accepted byte's
// result is registered in the queue before it reaches m_.
// A stalled receiver fills a four-entry queue; s_tready drops once it holds
// three items, so nothing is lost. Reset clears frame state and the queue
// and loads the register defaults (start word 0, version 0, limit 256).
// Registers are written through cfg_we/cfg_index/cfg_data by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module crc16_frame_deframer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // data_byte
    input  logic         s_tlast,    // buffer_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,    // payload_byte, status, msg_id, sequence_res,
                                     // timestamp, payload_length, received_crc, pad
    output logic         m_tuser,    // kind
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [15:0] start_reg, max_reg;
    logic [7:0]  ver_reg;
    logic        res_valid, room;
    crcfd_pkg::res_t res, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0; ver_reg <= '0; max_reg <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                crcfd_pkg::REG_START_WORD:  start_reg <= cfg_data;
                crcfd_pkg::REG_VERSION:     ver_reg <= cfg_data[7:0];
                crcfd_pkg::REG_MAX_PAYLOAD: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = room;

    crcfd_parser u_parser (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid && room), .in_byte(s_tdata), .in_end(s_tlast),
        .start_word(start_reg), .version_value(ver_reg), .max_payload(max_reg),
        .res_valid(res_valid), .res(res)
    );

    crcfd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(res_valid), .wr_data(res), .has_room(room),
        .rd_valid(m_tvalid), .rd_data(q_out), .rd_en(m_tready)
    );

    assign m_tuser = q_out.kind;
    assign m_tdata = {5'b0, q_out.received_crc, q_out.payload_length, q_out.timestamp,
                      q_out.sequence_res, q_out.msg_id, q_out.status, q_out.payload_byte};

endmodule
